/* rtl/oal_pkg.sv */
`default_nettype none

package oal_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int KIND_W       = 3;
    localparam int STAT_W       = 2;

    // cells per reduction group
    localparam int GRP_CELLS = 8;
    localparam int GRP_IW    = 3;

    // stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 3'd0,
        K_DELETE = 3'd1,
        K_GET    = 3'd2,
        K_LOCATE = 3'd3,
        K_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;   // open a slot at slot index, shift later entries up
        logic             del;   // close the slot, shift later entries down
        logic             rd;    // drive the entry at slot index onto the read tree
        logic             loc;   // compare every live entry with the value
        logic [POS_W-1:0] slot;  // 0-based position
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/oal_cell.sv */
`default_nettype none

module oal_cell #(
    parameter int IDX = 0,
    parameter int LW  = 7
) (
    input  wire                        i_clk,
    input  oal_pkg::t_cell_ctl         i_ctl,
    input  wire  [LW-1:0]              i_len,
    input  wire  [oal_pkg::DATA_W-1:0] i_val,
    input  wire  [oal_pkg::DATA_W-1:0] i_left,
    input  wire  [oal_pkg::DATA_W-1:0] i_right,
    output logic [oal_pkg::DATA_W-1:0] o_data,
    output logic [oal_pkg::DATA_W-1:0] o_pick,
    output logic                       o_match
);
    import oal_pkg::*;

    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;
    localparam logic [CW-1:0] J      = CW'(IDX);
    localparam logic [CW-1:0] J_NEXT = CW'(IDX + 1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic [CW-1:0]     w_slot;
    logic [CW-1:0]     w_len;

    assign w_slot = CW'(i_ctl.slot);
    assign w_len  = CW'(i_len);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (J == w_slot) begin
                n_data = i_val;
            end else if (J > w_slot && J <= w_len) begin
                n_data = i_left;
            end
        end else if (i_ctl.del) begin
            if (J >= w_slot && J_NEXT < w_len) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_pick  = (i_ctl.rd && J == w_slot) ? r_data : '0;
    assign o_match = i_ctl.loc && (J < w_len) && (r_data == i_val);

endmodule

`default_nettype wire

/* rtl/oal_group.sv */
`default_nettype none

module oal_group (
    input  wire                                               i_clk,
    input  wire                                               i_en,
    input  wire  [oal_pkg::GRP_CELLS-1:0][oal_pkg::DATA_W-1:0] i_pick,
    input  wire  [oal_pkg::GRP_CELLS-1:0]                     i_match,
    output logic [oal_pkg::DATA_W-1:0]                        o_or,
    output logic                                              o_hit,
    output logic [oal_pkg::GRP_IW-1:0]                        o_first
);
    import oal_pkg::*;

    logic [DATA_W-1:0] w_or;
    logic [GRP_IW-1:0] w_first;
    logic [DATA_W-1:0] r_or;
    logic              r_hit;
    logic [GRP_IW-1:0] r_first;

    // lowest matching cell wins
    always_comb begin
        w_or    = '0;
        w_first = '0;
        for (int i = GRP_CELLS - 1; i >= 0; i--) begin
            w_or = w_or | i_pick[i];
            if (i_match[i]) begin
                w_first = GRP_IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_or    <= w_or;
            r_hit   <= |i_match;
            r_first <= w_first;
        end
    end

    assign o_or    = r_or;
    assign o_hit   = r_hit;
    assign o_first = r_first;

endmodule

`default_nettype wire

/* rtl/ordered_array_list_engine.sv */
// Ordered array list engine: a positional list of signed 32-bit words.
//
// Input channel (s_axis): tuser carries the operation (insert, delete,
// get, locate, clear); tdata carries the 1-based position and the value.
// Output channel (m_axis): one result per request with status, the word
// read or removed, the position found by locate and the list length.
//
// Every entry sits in its own cell; the cells form a chain, so an insert
// or delete shifts the whole tail in the execute step, and every cell compares
// against the search value at once. Reads and search results fold through
// one registered tree of eight-cell groups.
//
// Steps per request: take (registered), execute in the chain (the group
// registers load), fold the group tree into the output register. A new
// request is taken only once the last result has entered the output register.
// A finished result waits in the output register; the next request is
// taken and executed meanwhile and holds in its last step until the
// output register frees. Reset empties the list (length zero); the cell
// contents are not cleared and need no clearing pass.
`default_nettype none

module ordered_array_list_engine #(
    parameter int CAPACITY = oal_pkg::DEF_CAPACITY
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // position [6:0], value [38:7], zero [39]
    input  wire  [oal_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // kind [2:0]
    input  wire  [oal_pkg::KIND_W-1:0]      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // status [1:0], data_out [33:2], found_position [40:34], count [47:41]
    output logic [oal_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import oal_pkg::*;

    localparam int LW  = $clog2(CAPACITY + 1);
    localparam int EW  = ((LW > POS_W) ? LW : POS_W) + 1;
    localparam int NG  = (CAPACITY + GRP_CELLS - 1) / GRP_CELLS;
    localparam int NCP = NG * GRP_CELLS;

    t_state r_state;
    t_state n_state;

    logic [KIND_W-1:0] r_kind;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_val;
    logic [LW-1:0]     r_len;
    logic [LW-1:0]     n_len;
    t_status           r_status;
    t_status           n_status;
    logic              r_is_loc;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic              w_take;
    logic              w_exec;
    logic              w_load;
    logic              w_rd_ok;
    logic              w_ins_ok;
    logic              w_full;
    logic [EW-1:0]     w_pos_ext;
    logic [EW-1:0]     w_len_ext;
    t_cell_ctl         w_op;
    t_cell_ctl         w_ctl;

    logic [CAPACITY-1:0][DATA_W-1:0] w_cell;
    logic [NCP-1:0][DATA_W-1:0]      w_pick;
    logic [NCP-1:0]                  w_match;

    logic [NG-1:0][DATA_W-1:0] w_grp_or;
    logic [NG-1:0]             w_grp_hit;
    logic [NG-1:0][GRP_IW-1:0] w_grp_first;

    logic [DATA_W-1:0] w_rd_data;
    logic              w_hit;
    logic [LW-1:0]     w_found;
    logic [EW-1:0]     w_found_ext;
    logic [EW-1:0]     w_count_ext;
    t_status           w_status;
    logic [POS_W-1:0]  w_found_out;

    // ---------------- request and control ----------------
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_exec          = (r_state == S_EXEC);
    assign w_load          = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind <= i_s_axis_tuser;
            r_pos  <= i_s_axis_tdata[POS_W-1:0];
            r_val  <= i_s_axis_tdata[POS_W +: DATA_W];
        end
    end

    assign w_pos_ext = EW'(r_pos);
    assign w_len_ext = EW'(r_len);
    assign w_rd_ok   = (w_pos_ext != '0) && (w_pos_ext <= w_len_ext);
    assign w_ins_ok  = (w_pos_ext != '0) && (w_pos_ext <= w_len_ext + 1'b1);
    assign w_full    = (r_len == LW'(CAPACITY));

    always_comb begin
        w_op      = '0;
        w_op.slot = r_pos - 1'b1;
        n_len     = r_len;
        n_status  = ST_OK;
        unique case (r_kind)
            K_INSERT: begin
                if (!w_ins_ok) begin
                    n_status = ST_BADPOS;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op.ins = 1'b1;
                    n_len    = r_len + 1'b1;
                end
            end
            K_DELETE: begin
                if (!w_rd_ok) begin
                    n_status = ST_BADPOS;
                end else begin
                    w_op.del = 1'b1;
                    w_op.rd  = 1'b1;
                    n_len    = r_len - 1'b1;
                end
            end
            K_GET: begin
                if (!w_rd_ok) begin
                    n_status = ST_BADPOS;
                end else begin
                    w_op.rd = 1'b1;
                end
            end
            K_LOCATE: begin
                w_op.loc = 1'b1;
            end
            K_CLEAR: begin
                n_len = '0;
            end
            default: begin
                n_len = r_len;
            end
        endcase
    end

    // drive the chain only in the execute step
    always_comb begin
        w_ctl     = w_op;
        w_ctl.ins = w_op.ins && w_exec;
        w_ctl.del = w_op.del && w_exec;
        w_ctl.rd  = w_op.rd  && w_exec;
        w_ctl.loc = w_op.loc && w_exec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (w_exec) begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_status <= n_status;
            r_is_loc <= w_op.loc;
        end
    end

    // ---------------- cell chain ----------------
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        if (j == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_cell[j-1];
        end
        if (j == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_cell[j+1];
        end

        oal_cell #(
            .IDX (j),
            .LW  (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_len   (r_len),
            .i_val   (r_val),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[j]),
            .o_pick  (w_pick[j]),
            .o_match (w_match[j])
        );
    end

    for (genvar j = CAPACITY; j < NCP; j++) begin : g_pad
        assign w_pick[j]  = '0;
        assign w_match[j] = 1'b0;
    end

    // ---------------- group tree ----------------
    for (genvar g = 0; g < NG; g++) begin : g_grp
        oal_group u_group (
            .i_clk   (i_clk),
            .i_en    (w_exec),
            .i_pick  (w_pick[g*GRP_CELLS +: GRP_CELLS]),
            .i_match (w_match[g*GRP_CELLS +: GRP_CELLS]),
            .o_or    (w_grp_or[g]),
            .o_hit   (w_grp_hit[g]),
            .o_first (w_grp_first[g])
        );
    end

    always_comb begin
        w_rd_data = '0;
        w_found   = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            w_rd_data = w_rd_data | w_grp_or[g];
            if (w_grp_hit[g]) begin
                w_found = LW'(g * GRP_CELLS) + LW'(w_grp_first[g]) + 1'b1;
            end
        end
    end

    assign w_hit       = |w_grp_hit;
    assign w_status    = r_is_loc ? (w_hit ? ST_OK : ST_NOTFOUND) : r_status;
    assign w_found_ext = (r_is_loc && w_hit) ? EW'(w_found) : '0;
    assign w_count_ext = EW'(r_len);
    assign w_found_out = w_found_ext[POS_W-1:0];

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {w_count_ext[POS_W-1:0], w_found_out, w_rd_data, w_status};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("list length above capacity");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_len == $past(r_len) + 1'b1))
        else $error("insert did not grow the list");

    a_del_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.del |=> (r_len == $past(r_len) - 1'b1))
        else $error("delete did not shrink the list");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && r_kind == K_CLEAR) |=> (r_len == '0))
        else $error("clear left entries");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_ctl.ins, w_ctl.del, w_ctl.loc}))
        else $error("more than one chain operation at once");
`endif

endmodule

`default_nettype wire
